FILE: rtl/s2a_pkg.sv
// Shared constants for the set-1 scan code to ASCII decoder.
// Used by s2a_keymap and scancode_to_ascii_decoder_core; no dependencies.
package s2a_pkg;

    // Field widths
    localparam int SCAN_W  = 8;
    localparam int CODE_W  = 7;
    localparam int ASCII_W = 7;
    localparam int OUT_W   = 8;

    // Special scan codes
    localparam logic [SCAN_W-1:0] CODE_PREFIX = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h36;

    // No character for this key
    localparam logic [ASCII_W-1:0] CHAR_NONE = 7'h00;

endpackage

FILE: rtl/scancode_to_ascii_decoder_core.sv
// A scan code byte is held in the input register, and its character then in the result
// register, loaded when that register is free or being drained.
// Throughput: one byte per cycle while the output is not stalled; the input register advances
// whenever the result register is empty or being drained, so a stalled output holds at most two bytes.
// Reset (rst_n low, asynchronous) clears shift and prefix flags and both valid flags.
// Depends on s2a_pkg and s2a_keymap.
module scancode_to_ascii_decoder_core
    import s2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [SCAN_W-1:0] s_axis_tdata,  // [7:0] scan_code
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata   // [6:0] ascii_char, [7] zero
);

    logic               in_valid_reg;
    logic [SCAN_W-1:0]  in_code_reg;
    logic               shift_reg;
    logic               shift_next;
    logic               prefix_reg;
    logic               prefix_next;
    logic               out_valid_reg;
    logic [ASCII_W-1:0] out_char_reg;
    logic               advance;
    logic               emit;
    logic [CODE_W-1:0]  low_code;
    logic               low_is_shift;
    logic [ASCII_W-1:0] map_char;

    // Move the input register on when the result slot is free or being taken
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold one scan code byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_code_reg <= s_axis_tdata;
    end

    assign low_code     = in_code_reg[CODE_W-1:0];
    assign low_is_shift = (low_code == CODE_LSHIFT) || (low_code == CODE_RSHIFT);

    s2a_keymap u_keymap
    (
        .code       (low_code),
        .shift      (shift_reg),
        .ascii_char (map_char)
    );

    // Decode the byte: prefix, break, shift make, extended make, ordinary make
    always_comb
    begin
        shift_next  = shift_reg;
        prefix_next = prefix_reg;
        emit        = 1'b0;
        if (in_code_reg == CODE_PREFIX)
        begin
            prefix_next = 1'b1;
        end
        else if (in_code_reg[SCAN_W-1])
        begin
            prefix_next = 1'b0;
            if (low_is_shift)
                shift_next = 1'b0;
        end
        else if (low_is_shift)
        begin
            shift_next = 1'b1;
        end
        else if (prefix_reg)
        begin
            prefix_next = 1'b0;
        end
        else
        begin
            emit = (map_char != CHAR_NONE);
        end
    end

    // Update the key flags once per transfer out of the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= 1'b0;
            prefix_reg <= 1'b0;
        end
        else if (advance)
        begin
            shift_reg  <= shift_next;
            prefix_reg <= prefix_next;
        end
    end

    // Result register: load on an emitting byte, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= emit;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_char_reg <= map_char;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-ASCII_W){1'b0}}, out_char_reg};

`ifndef SYNTH
    // A delivered character is never the empty code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ASCII_W-1:0] != CHAR_NONE))
        else $error("empty character offered");

    // A prefix byte arms the prefix and emits nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_code_reg == CODE_PREFIX)) |=> (prefix_reg && !out_valid_reg))
        else $error("prefix byte mishandled");

    // A shift make sets shift; a shift break clears it
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_code_reg[SCAN_W-1] && low_is_shift) |=> shift_reg)
        else $error("shift make did not set shift");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_code_reg != CODE_PREFIX) && in_code_reg[SCAN_W-1] && low_is_shift)
        |=> (!shift_reg && !prefix_reg))
        else $error("shift break did not clear flags");
`endif

endmodule

FILE: rtl/s2a_keymap.sv
// Key map for set-1 make codes: plain and shifted ASCII per 7-bit code.
// Depends on s2a_pkg for widths and the no-character code.
module s2a_keymap
    import s2a_pkg::*;
(
    input  logic [CODE_W-1:0]  code,
    input  logic               shift,
    output logic [ASCII_W-1:0] ascii_char
);

    logic [ASCII_W-1:0] plain_char;
    logic [ASCII_W-1:0] shift_char;

    // Look up both tables; codes without a key read as no character
    always_comb
    begin
        plain_char = CHAR_NONE;
        shift_char = CHAR_NONE;
        case (code)
            7'h01: begin plain_char = 7'h1B; shift_char = 7'h1B; end
            7'h02: begin plain_char = 7'h31; shift_char = 7'h21; end
            7'h03: begin plain_char = 7'h32; shift_char = 7'h40; end
            7'h04: begin plain_char = 7'h33; shift_char = 7'h23; end
            7'h05: begin plain_char = 7'h34; shift_char = 7'h24; end
            7'h06: begin plain_char = 7'h35; shift_char = 7'h25; end
            7'h07: begin plain_char = 7'h36; shift_char = 7'h5E; end
            7'h08: begin plain_char = 7'h37; shift_char = 7'h26; end
            7'h09: begin plain_char = 7'h38; shift_char = 7'h2A; end
            7'h0A: begin plain_char = 7'h39; shift_char = 7'h28; end
            7'h0B: begin plain_char = 7'h30; shift_char = 7'h29; end
            7'h0C: begin plain_char = 7'h2D; shift_char = 7'h5F; end
            7'h0D: begin plain_char = 7'h3D; shift_char = 7'h2B; end
            7'h0E: begin plain_char = 7'h08; shift_char = 7'h08; end
            7'h0F: begin plain_char = 7'h09; shift_char = 7'h09; end
            7'h10: begin plain_char = 7'h71; shift_char = 7'h51; end
            7'h11: begin plain_char = 7'h77; shift_char = 7'h57; end
            7'h12: begin plain_char = 7'h65; shift_char = 7'h45; end
            7'h13: begin plain_char = 7'h72; shift_char = 7'h52; end
            7'h14: begin plain_char = 7'h74; shift_char = 7'h54; end
            7'h15: begin plain_char = 7'h79; shift_char = 7'h59; end
            7'h16: begin plain_char = 7'h75; shift_char = 7'h55; end
            7'h17: begin plain_char = 7'h69; shift_char = 7'h49; end
            7'h18: begin plain_char = 7'h6F; shift_char = 7'h4F; end
            7'h19: begin plain_char = 7'h70; shift_char = 7'h50; end
            7'h1A: begin plain_char = 7'h5B; shift_char = 7'h7B; end
            7'h1B: begin plain_char = 7'h5D; shift_char = 7'h7D; end
            7'h1C: begin plain_char = 7'h0A; shift_char = 7'h0A; end
            7'h1E: begin plain_char = 7'h61; shift_char = 7'h41; end
            7'h1F: begin plain_char = 7'h73; shift_char = 7'h53; end
            7'h20: begin plain_char = 7'h64; shift_char = 7'h44; end
            7'h21: begin plain_char = 7'h66; shift_char = 7'h46; end
            7'h22: begin plain_char = 7'h67; shift_char = 7'h47; end
            7'h23: begin plain_char = 7'h68; shift_char = 7'h48; end
            7'h24: begin plain_char = 7'h6A; shift_char = 7'h4A; end
            7'h25: begin plain_char = 7'h6B; shift_char = 7'h4B; end
            7'h26: begin plain_char = 7'h6C; shift_char = 7'h4C; end
            7'h27: begin plain_char = 7'h3B; shift_char = 7'h3A; end
            7'h28: begin plain_char = 7'h27; shift_char = 7'h22; end
            7'h29: begin plain_char = 7'h60; shift_char = 7'h7E; end
            7'h2B: begin plain_char = 7'h5C; shift_char = 7'h7C; end
            7'h2C: begin plain_char = 7'h7A; shift_char = 7'h5A; end
            7'h2D: begin plain_char = 7'h78; shift_char = 7'h58; end
            7'h2E: begin plain_char = 7'h63; shift_char = 7'h43; end
            7'h2F: begin plain_char = 7'h76; shift_char = 7'h56; end
            7'h30: begin plain_char = 7'h62; shift_char = 7'h42; end
            7'h31: begin plain_char = 7'h6E; shift_char = 7'h4E; end
            7'h32: begin plain_char = 7'h6D; shift_char = 7'h4D; end
            7'h33: begin plain_char = 7'h2C; shift_char = 7'h3C; end
            7'h34: begin plain_char = 7'h2E; shift_char = 7'h3E; end
            7'h35: begin plain_char = 7'h2F; shift_char = 7'h3F; end
            7'h37: begin plain_char = 7'h2A; shift_char = 7'h2A; end
            7'h39: begin plain_char = 7'h20; shift_char = 7'h20; end
            default:
            begin
                plain_char = CHAR_NONE;
                shift_char = CHAR_NONE;
            end
        endcase
    end

    // Select the table by shift state
    assign ascii_char = shift ? shift_char : plain_char;

endmodule
